// ----- rtl/contiguous_point_list_core_assert.svh -----
// Assertion macros for the contiguous point list core.
// Expects clk and arst_n in the scope of every use.
`ifndef CONTIGUOUS_POINT_LIST_CORE_ASSERT_SVH
`define CONTIGUOUS_POINT_LIST_CORE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define CPL_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define CPL_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/cpl_pkg.sv -----
// Shared types and constants of the contiguous point list core.
// No dependencies; every design module imports it.
package cpl_pkg;

	localparam int COORD_W   = 16;
	localparam int PT_W      = 2 * COORD_W;
	localparam int IDX_W     = 6;
	localparam int CAP_W     = 7;
	localparam int POS_W     = 10;
	localparam int GRP       = 8;
	localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

	typedef enum logic [2:0] {
		ACT_GET       = 3'd0,
		ACT_SET       = 3'd1,
		ACT_INS_AT    = 3'd2,
		ACT_REM_AT    = 3'd3,
		ACT_APPEND    = 3'd4,
		ACT_DROP_LAST = 3'd5,
		ACT_INS_FRONT = 3'd6,
		ACT_REM_FRONT = 3'd7
	} action_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_BAD_INDEX = 2'd1,
		ST_FULL      = 2'd2,
		ST_EMPTY     = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		OP_HOLD   = 2'd0,
		OP_WRITE  = 2'd1,
		OP_INSERT = 2'd2,
		OP_DELETE = 2'd3
	} cell_op_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
	} point_t;

	typedef struct packed {
		cell_op_t         op;
		logic [POS_W-1:0] pos;
	} cell_cmd_t;

	typedef struct packed {
		action_t                   action;
		logic [IDX_W-1:0]          index;
		logic signed [COORD_W-1:0] point_x;
		logic signed [COORD_W-1:0] point_y;
	} req_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] read_x;
		logic signed [COORD_W-1:0] read_y;
		status_t                   status;
		logic [CAP_W-1:0]          count;
	} rsp_t;

endpackage

// ----- rtl/cpl_cell.sv -----
// One list slot of the cell chain: holds a point, takes a neighbor's on a shift.
// Depends on cpl_pkg.
module cpl_cell #(
	parameter int IDX = 0
) (
	input  logic               clk,
	input  cpl_pkg::cell_cmd_t cmd,
	input  cpl_pkg::point_t    wr_pt,
	input  cpl_pkg::point_t    from_lo,
	input  cpl_pkg::point_t    from_hi,
	output cpl_pkg::point_t    pt
);
	import cpl_pkg::*;

	localparam logic [POS_W-1:0] MY_POS = POS_W'(IDX);

	point_t pt_q;

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_WRITE: begin
				if (cmd.pos == MY_POS) pt_q <= wr_pt;
			end
			OP_INSERT: begin
				// shift up above the slot, load the new point at it
				if (MY_POS > cmd.pos) pt_q <= from_lo;
				else if (MY_POS == cmd.pos) pt_q <= wr_pt;
			end
			OP_DELETE: begin
				if (MY_POS >= cmd.pos) pt_q <= from_hi;
			end
			default: begin
				pt_q <= pt_q;
			end
		endcase
	end

	assign pt = pt_q;

endmodule

// ----- rtl/cpl_read_tree.sv -----
// Registered two-level select that reads one slot out of the cell chain.
// Depends on cpl_pkg.
module cpl_read_tree #(
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     load,
	input  logic [cpl_pkg::POS_W-1:0] rd_pos,
	input  cpl_pkg::point_t          vals [DEPTH],
	output cpl_pkg::point_t          rd_pt
);
	import cpl_pkg::*;

	localparam int NG = (DEPTH + GRP - 1) / GRP;

	logic [PT_W-1:0] masked [NG*GRP];
	logic [PT_W-1:0] grp_s1 [NG];
	logic [PT_W-1:0] merged;

	for (genvar i = 0; i < NG * GRP; i++) begin : g_mask
		if (i < DEPTH) begin : g_real
			assign masked[i] = (rd_pos == POS_W'(i)) ? vals[i] : '0;
		end else begin : g_pad
			assign masked[i] = '0;
		end
	end

	// first level: one OR per group of slots, held until the next load
	always_ff @(posedge clk) begin
		if (load) begin
			for (int g = 0; g < NG; g++) begin
				grp_s1[g] <= masked[g*GRP]   | masked[g*GRP+1] | masked[g*GRP+2] |
				             masked[g*GRP+3] | masked[g*GRP+4] | masked[g*GRP+5] |
				             masked[g*GRP+6] | masked[g*GRP+7];
			end
		end
	end

	always_comb begin
		merged = '0;
		for (int g = 0; g < NG; g++) begin
			merged = merged | grp_s1[g];
		end
	end

	assign rd_pt = point_t'(merged);

endmodule

// ----- rtl/contiguous_point_list_core.sv -----
// Contiguous point list core: an ordered list of (x,y) points packed from slot 0,
// held in a chain of DEPTH cells that all shift in the same cycle, so every action
// (get, set, insert at, remove at, append, drop last, insert front, remove front)
// is applied to the list by the cells as its request transfers. One request is taken
// per cycle for as long as responses are drained; a response is registered first in
// stage 1, alongside the registered read select across the cells, and then in the
// response register. Failed actions leave the list untouched and report a status;
// every response carries the new count. The capacity register may be written only
// while no request is in flight; the effective capacity is the smaller of the
// register and DEPTH. No slot above the count reaches a response. Depends on
// cpl_pkg, cpl_cell, cpl_read_tree and the assertion macro header.
`include "contiguous_point_list_core_assert.svh"

module contiguous_point_list_core #(
	parameter int DEPTH = 64
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      req_valid,
	output logic                      req_ready,
	input  cpl_pkg::req_t             req,
	output logic                      rsp_valid,
	input  logic                      rsp_ready,
	output cpl_pkg::rsp_t             rsp,
	input  logic                      cfg_we,
	input  logic [cpl_pkg::CAP_W-1:0] cfg_wdata
);
	import cpl_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);
	localparam int UW = (CW > CAP_W) ? CW : CAP_W;

	// list state and capacity
	logic [CW-1:0]    used_q;
	logic [CAP_W-1:0] cap_q;

	// decode of the request against the current count
	logic [UW-1:0] used_ext, cap_ext, depth_ext, cap_eff, k_ext;
	logic          full, empty, k_ok;
	cell_cmd_t     cmd_c, cell_cmd;
	status_t       st_c;
	logic [CW-1:0] used_d;
	logic          get_ok_c;
	logic          accept;

	// stage 1 and response register
	logic          valid_s1;
	status_t       status_s1;
	logic [CW-1:0] count_s1;
	logic          get_ok_s1;
	logic          rsp_valid_q;
	rsp_t          rsp_q;
	logic          adv;

	point_t        wr_pt;
	point_t        vals [DEPTH];
	point_t        rd_pt;

	assign used_ext  = UW'(used_q);
	assign cap_ext   = UW'(cap_q);
	assign depth_ext = UW'(DEPTH);
	assign cap_eff   = (cap_ext > depth_ext) ? depth_ext : cap_ext;
	assign full      = used_ext >= cap_eff;
	assign empty     = (used_q == '0);
	assign k_ext     = UW'(req.index);
	assign k_ok      = k_ext < used_ext;

	always_comb begin
		cmd_c.op  = OP_HOLD;
		cmd_c.pos = POS_W'(req.index);
		st_c      = ST_OK;
		used_d    = used_q;
		get_ok_c  = 1'b0;
		unique case (req.action)
			ACT_GET: begin
				if (k_ok) get_ok_c = 1'b1;
				else st_c = ST_BAD_INDEX;
			end
			ACT_SET: begin
				if (k_ok) cmd_c.op = OP_WRITE;
				else st_c = ST_BAD_INDEX;
			end
			ACT_INS_AT: begin
				// full check wins over the index check
				if (full) st_c = ST_FULL;
				else if (!k_ok) st_c = ST_BAD_INDEX;
				else begin
					cmd_c.op = OP_INSERT;
					used_d   = used_q + CW'(1);
				end
			end
			ACT_REM_AT: begin
				if (!k_ok) st_c = ST_BAD_INDEX;
				else begin
					cmd_c.op = OP_DELETE;
					used_d   = used_q - CW'(1);
				end
			end
			ACT_APPEND: begin
				if (full) st_c = ST_FULL;
				else begin
					cmd_c.op  = OP_WRITE;
					cmd_c.pos = POS_W'(used_q);
					used_d    = used_q + CW'(1);
				end
			end
			ACT_DROP_LAST: begin
				if (empty) st_c = ST_EMPTY;
				else used_d = used_q - CW'(1);
			end
			ACT_INS_FRONT: begin
				if (full) st_c = ST_FULL;
				else begin
					cmd_c.op  = OP_INSERT;
					cmd_c.pos = '0;
					used_d    = used_q + CW'(1);
				end
			end
			ACT_REM_FRONT: begin
				// removing from an empty list is an index error on slot 0
				if (empty) st_c = ST_BAD_INDEX;
				else begin
					cmd_c.op  = OP_DELETE;
					cmd_c.pos = '0;
					used_d    = used_q - CW'(1);
				end
			end
			default: begin
				st_c = ST_OK;
			end
		endcase
	end

	// advance stage 1 whenever the response register is free or draining
	assign adv       = !rsp_valid_q || rsp_ready;
	assign req_ready = !valid_s1 || adv;
	assign accept    = req_valid && req_ready;

	// hold every cell unless a request transfers this cycle
	assign cell_cmd  = accept ? cmd_c : cell_cmd_t'{op: OP_HOLD, pos: '0};
	assign wr_pt.x   = req.point_x;
	assign wr_pt.y   = req.point_y;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		cpl_cell #(
			.IDX(i)
		) u_cell (
			.clk    (clk),
			.cmd    (cell_cmd),
			.wr_pt  (wr_pt),
			.from_lo(vals[(i == 0) ? 0 : i - 1]),
			.from_hi(vals[(i == DEPTH - 1) ? DEPTH - 1 : i + 1]),
			.pt     (vals[i])
		);
	end

	// read select runs alongside the update; the list reads as before the action
	cpl_read_tree #(
		.DEPTH(DEPTH)
	) u_read_tree (
		.clk   (clk),
		.load  (accept),
		.rd_pos(POS_W'(req.index)),
		.vals  (vals),
		.rd_pt (rd_pt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q      <= '0;
			cap_q       <= CAP_RESET;
			valid_s1    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_we) cap_q <= cfg_wdata;
			if (accept) used_q <= used_d;
			if (accept) valid_s1 <= 1'b1;
			else if (adv) valid_s1 <= 1'b0;
			if (adv) rsp_valid_q <= valid_s1;
		end
	end

	// stage 1 metadata and the response payload carry no reset
	always_ff @(posedge clk) begin
		if (accept) begin
			status_s1 <= st_c;
			count_s1  <= used_d;
			get_ok_s1 <= get_ok_c;
		end
		if (valid_s1 && adv) begin
			rsp_q.read_x <= get_ok_s1 ? rd_pt.x : '0;
			rsp_q.read_y <= get_ok_s1 ? rd_pt.y : '0;
			rsp_q.status <= status_s1;
			rsp_q.count  <= CAP_W'(count_s1);
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	`CPL_ASSERT_IMP(a_used_bound, 1'b1, used_q <= CW'(DEPTH), "count above depth")
	`CPL_ASSERT_NXT(a_fail_keeps_count, accept && st_c != ST_OK, used_q == $past(used_q),
		"failed action changed the count")
	`CPL_ASSERT_NXT(a_grow_by_one,
		accept && st_c == ST_OK && (req.action == ACT_INS_AT || req.action == ACT_APPEND ||
		req.action == ACT_INS_FRONT), used_q == $past(used_q) + CW'(1),
		"insertion did not grow the list by one")
	`CPL_ASSERT_IMP(a_read_zero, rsp_valid_q && rsp_q.status != ST_OK,
		rsp_q.read_x == '0 && rsp_q.read_y == '0, "failed response carries a point")
	`CPL_ASSERT_IMP(a_stall_source, !req_ready, valid_s1 && rsp_valid_q && !rsp_ready,
		"request stalled without a blocked response")

endmodule
